// ===== hdl/iida_pkg.sv =====
// Package for the indexed insert/delete list engine.
// It holds the request codes, the cell commands and the result record.
// It depends on nothing else.
`default_nettype none

package iida_pkg;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_DELETE = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_CLEAR  = 3'd4
    } t_cell_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op    op;
        logic [31:0] data;
    } t_cell_cmd;

    // One result item.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         length;
        logic               accepted;
    } t_result;

    localparam int unsigned FIELD_W = 7;
    localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== hdl/iida_cell.sv =====
// One cell of the list chain: holds a single entry.
// It takes its next value from the broadcast command or from a neighbor.
// Depends on iida_pkg.
`default_nettype none

module iida_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  iida_pkg::t_cell_cmd   i_cmd,
    input  wire [CW-1:0]          i_pos,
    input  wire [CW-1:0]          i_len,
    input  wire [31:0]            i_left,
    input  wire [31:0]            i_right,
    output logic [31:0]           o_value,
    output logic [31:0]           o_tap
);

    logic [31:0] r_value;
    logic [31:0] n_value;
    logic        w_at_pos;
    logic        w_above_pos;
    logic        w_below_pos;
    logic        w_last;

    assign w_at_pos    = (i_pos == CW'(IDX));
    assign w_above_pos = (CW'(IDX) > i_pos);
    assign w_below_pos = (CW'(IDX) < i_pos);
    assign w_last      = (i_len == CW'(IDX + 1));

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            iida_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            iida_pkg::CELL_WRITE: begin
                if (w_at_pos) begin
                    n_value = i_cmd.data;
                end
            end
            iida_pkg::CELL_INSERT: begin
                // Cells from the position up to the old length move up by one.
                if (w_at_pos) begin
                    n_value = i_cmd.data;
                end else if (w_above_pos && (CW'(IDX) <= i_len)) begin
                    n_value = i_left;
                end
            end
            iida_pkg::CELL_DELETE: begin
                // The old top cell is vacated, the rest above the position move down.
                if (w_last) begin
                    n_value = '0;
                end else if (!w_below_pos && (CW'(IDX + 1) < i_len)) begin
                    n_value = i_right;
                end
            end
            iida_pkg::CELL_CLEAR: begin
                n_value = '0;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_tap   = w_at_pos ? r_value : '0;

endmodule

`default_nettype wire

// ===== hdl/iida_result_queue.sv =====
// Two-entry result queue between the list chain and the output channel.
// It lets a new request enter while an earlier result waits downstream.
// Depends on iida_pkg.
`default_nettype none

module iida_result_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  iida_pkg::t_result   i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_stall,
    output iida_pkg::t_result   o_data
);

    iida_pkg::t_result r_slot [2];
    logic              r_head;
    logic              r_tail;
    logic [1:0]        r_count;
    logic              w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_slot[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_tail <= ~r_tail;
            end
            if (w_pop) begin
                r_head <= ~r_head;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/indexed_insert_delete_array_core.sv =====
// Top level of the indexed insert/delete list engine.
// Instantiates the chain of iida_cell entries and the iida_result_queue.
// Depends on iida_pkg.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_req_type, i_position, i_data
//   result    out        o_out_valid / i_out_stall o_read_value, o_length, o_accepted
//   config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One request is taken per cycle. The whole chain of cells updates at the
// edge that accepts the request, and its result is registered in a two-entry
// queue before it shows on the output. A read drives its entry through
// an OR tree over all cells, which is the longest path of the block.
// Reset and a write of start_length clear every cell and load the length.
// The request side stalls only while both queue slots hold results that the
// output side has not taken.
`default_nettype none

module indexed_insert_delete_array_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // Request channel.
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire [1:0]         i_req_type,
    input  wire [6:0]         i_position,
    input  wire signed [31:0] i_data,
    // Result channel.
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [31:0] o_read_value,
    output logic [6:0]        o_length,
    output logic              o_accepted,
    // Configuration port.
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Width of the length counter, and a compare width that covers both the
    // counter and the seven-bit position field.
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (LW > iida_pkg::FIELD_W) ? LW : iida_pkg::FIELD_W;

    logic [6:0]          r_start;
    logic [LW-1:0]       r_length;
    logic [LW-1:0]       n_length;

    iida_pkg::t_cell_cmd w_cmd;
    iida_pkg::t_result   w_result;
    iida_pkg::t_result   w_out;
    iida_pkg::t_req_type w_req;

    logic                w_in_take;
    logic                w_cfg_write;
    logic                w_full;
    logic                w_in_range;
    logic                w_list_full;
    logic [CW-1:0]       w_pos;
    logic [CW-1:0]       w_len;
    logic [LW-1:0]       w_start_sat;
    logic [31:0]         w_read_bits;

    logic [31:0]         w_value [MAX_ENTRIES];
    logic [31:0]         w_tap   [MAX_ENTRIES];

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata      = (paddr[2] == 1'b0) ? 32'(r_start) : '0;

    // A start length beyond the capacity saturates to the capacity.
    assign w_start_sat = (CW'(pwdata[6:0]) > CW'(MAX_ENTRIES)) ?
                         LW'(MAX_ENTRIES) : LW'(pwdata[6:0]);

    assign o_in_stall  = w_full;
    assign w_in_take   = i_in_valid && !w_full;
    assign w_req       = iida_pkg::t_req_type'(i_req_type);
    assign w_pos       = CW'(i_position);
    assign w_len       = CW'(r_length);
    assign w_in_range  = (w_pos < w_len);
    assign w_list_full = (r_length == LW'(MAX_ENTRIES));

    // The read data comes from the single cell whose index matches.
    always_comb begin
        w_read_bits = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_read_bits = w_read_bits | w_tap[k];
        end
    end

    always_comb begin
        w_cmd.op            = iida_pkg::CELL_HOLD;
        w_cmd.data          = i_data;
        n_length            = r_length;
        w_result.read_value = '0;
        w_result.accepted   = 1'b0;
        if (w_in_take) begin
            unique case (w_req)
                iida_pkg::REQ_READ: begin
                    if (w_in_range) begin
                        w_result.read_value = $signed(w_read_bits);
                        w_result.accepted   = 1'b1;
                    end else begin
                        w_result.read_value = $signed(iida_pkg::READ_MISS);
                    end
                end
                iida_pkg::REQ_WRITE: begin
                    if (w_in_range) begin
                        w_cmd.op          = iida_pkg::CELL_WRITE;
                        w_result.accepted = 1'b1;
                    end
                end
                iida_pkg::REQ_INSERT: begin
                    // Appending at the current length is allowed; a full list rejects.
                    if ((w_pos <= w_len) && !w_list_full) begin
                        w_cmd.op          = iida_pkg::CELL_INSERT;
                        n_length          = r_length + LW'(1);
                        w_result.accepted = 1'b1;
                    end
                end
                iida_pkg::REQ_DELETE: begin
                    if (w_in_range) begin
                        w_cmd.op          = iida_pkg::CELL_DELETE;
                        n_length          = r_length - LW'(1);
                        w_result.accepted = 1'b1;
                    end
                end
                default: begin
                    w_cmd.op = iida_pkg::CELL_HOLD;
                end
            endcase
        end
        // A configuration write must arrive only while the block is idle; the block itself does not enforce this.
        if (w_cfg_write) begin
            w_cmd.op = iida_pkg::CELL_CLEAR;
            n_length = w_start_sat;
        end
        w_result.length = 7'(n_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_length <= '0;
        end else begin
            if (w_cfg_write) begin
                r_start <= pwdata[6:0];
            end
            r_length <= n_length;
        end
    end

    // The chain: each cell sees its lower neighbor for an insert and its
    // upper neighbor for a delete. The ends of the chain see zero.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_left
            assign w_left = w_value[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_top
            assign w_right = '0;
        end else begin : g_inner_right
            assign w_right = w_value[g+1];
        end

        iida_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_len   (w_len),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_tap   (w_tap[g])
        );
    end

    iida_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_take),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_read_value = w_out.read_value;
    assign o_length     = w_out.length;
    assign o_accepted   = w_out.accepted;

endmodule

`default_nettype wire

// ===== dv/indexed_insert_delete_array_core_tb.sv =====
// Self-checking testbench for the indexed insert/delete list engine.
// Drives requests and register writes (start_length and an unmapped address), predicts every result and checks it.
// Depends on iida_pkg and indexed_insert_delete_array_core.

module indexed_insert_delete_array_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Depth of the list under test; the block is built with the same value.
    localparam int LIST_DEPTH = 64;

    // Byte addresses on the configuration port. Only start_length is mapped;
    // the next word slot is used to show that unmapped writes are ignored.
    localparam logic [2:0] REG_START_LENGTH = 3'd0;
    localparam logic [2:0] REG_UNMAPPED     = 3'd4;

    // The run is cut off here if it has not finished.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Values at the edges of the signed data range, and all ones.
    localparam logic [31:0] DATA_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] DATA_MIN  = 32'h8000_0000;
    localparam logic [31:0] DATA_ONES = 32'hFFFF_FFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic [6:0]         i_position;
    logic signed [31:0] i_data;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_read_value;
    logic [6:0]         o_length;
    logic               o_accepted;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    indexed_insert_delete_array_core #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_data      (i_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_value(o_read_value),
        .o_length    (o_length),
        .o_accepted  (o_accepted),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the list. It is advanced once per accepted request, in
    // the same order as the block sees them, so the front of awaited_results
    // is always the next result the block must produce.
    // ------------------------------------------------------------------
    logic [31:0]       shadow_cells [LIST_DEPTH];
    int                shadow_len;
    logic [6:0]        shadow_start;
    iida_pkg::t_result awaited_results [$];

    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned config_writes;
    int unsigned accepted_by_kind [4];
    int unsigned cycle_count;

    // When set, the receiver never stalls, so a phase can run at full rate.
    bit receiver_quiet;

    // Clears every cell and loads the length from start_length, saturating
    // at the list depth, as a reset or a register write does in the block.
    function automatic void load_start_length();
        foreach (shadow_cells[k]) shadow_cells[k] = '0;
        shadow_len = (shadow_start > LIST_DEPTH) ? LIST_DEPTH : int'(shadow_start);
    endfunction

    // Applies one request to the shadow list and returns the result that the
    // block has to report for it.
    function automatic iida_pkg::t_result apply_list_request(iida_pkg::t_req_type kind,
                                                             int pos, logic [31:0] value);
        iida_pkg::t_result r;
        r.read_value = '0;
        r.accepted   = 1'b0;
        case (kind)
            iida_pkg::REQ_READ: begin
                // A read past the end reports the miss pattern.
                if (pos < shadow_len) begin
                    r.read_value = shadow_cells[pos];
                    r.accepted   = 1'b1;
                end else begin
                    r.read_value = iida_pkg::READ_MISS;
                end
            end
            iida_pkg::REQ_WRITE: begin
                if (pos < shadow_len) begin
                    shadow_cells[pos] = value;
                    r.accepted        = 1'b1;
                end
            end
            iida_pkg::REQ_INSERT: begin
                // Appending at the length is legal; a full list refuses.
                if (pos <= shadow_len && shadow_len < LIST_DEPTH) begin
                    for (int k = shadow_len; k > pos; k--)
                        shadow_cells[k] = shadow_cells[k - 1];
                    shadow_cells[pos] = value;
                    shadow_len++;
                    r.accepted = 1'b1;
                end
            end
            default: begin
                // Delete: later entries move down and the cell left free at
                // the top of the list reads back as zero.
                if (pos < shadow_len) begin
                    for (int k = pos; k + 1 < shadow_len; k++)
                        shadow_cells[k] = shadow_cells[k + 1];
                    shadow_len--;
                    shadow_cells[shadow_len] = '0;
                    r.accepted = 1'b1;
                end
            end
        endcase
        r.length = shadow_len[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and watchdog.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls on a pattern of its own, picked at random for each
    // span of random length: no stalls, sparse random stalls, heavy stalls, or a
    // strict alternation. Each pattern lands gaps on a different phase of
    // the result queue filling and draining.
    // ------------------------------------------------------------------
    initial begin : receiver_stall_pattern
        int unsigned mode;
        int unsigned span;
        i_out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(posedge i_clk);
                if (receiver_quiet || mode == 0)
                    i_out_stall <= 1'b0;
                else if (mode == 1)
                    i_out_stall <= ($urandom_range(0, 2) == 0);
                else if (mode == 2)
                    i_out_stall <= ($urandom_range(0, 7) != 0);
                else
                    i_out_stall <= ~i_out_stall;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker. A transfer on the result channel happens at an edge
    // where o_out_valid is high and i_out_stall is low; both are read here
    // before any update of that edge takes effect.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_checker
        iida_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with no result awaited: read_value %h length %0d",
                       o_read_value, o_length);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_read_value);
                    mismatch_count++;
                end
                if (o_length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_length);
                    mismatch_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0b, got %0b", want.accepted, o_accepted);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every task here is entered right after a rising edge.
    // i_in_valid is raised only by send_request and lowered only by
    // pause_sender and drain_results, and each of those waits for a clock
    // edge after driving it, so valid never gets two assignments in one time step.
    // ------------------------------------------------------------------

    // Offers one request and waits for its transfer; the expected result is
    // worked out at the accepting edge.
    task automatic send_request(iida_pkg::t_req_type kind, logic [6:0] pos,
                                logic [31:0] value);
        iida_pkg::t_result r;
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_position <= pos;
        i_data     <= value;
        do @(posedge i_clk); while (o_in_stall);
        r = apply_list_request(kind, int'(pos), value);
        awaited_results.push_back(r);
        requests_sent++;
        accepted_by_kind[kind] += r.accepted;
    endtask

    task automatic pause_sender(int unsigned cycles);
        if (cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every awaited result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access phase meets pready. Only called while idle.
    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == REG_START_LENGTH) begin
            shadow_start = value[6:0];
            load_start_length();
        end
        config_writes++;
    endtask

    // A drain followed by a spare wait leaves the block idle before a register write.
    task automatic settle_and_configure(logic [2:0] addr, logic [31:0] value);
        drain_results();
        repeat (2) @(posedge i_clk);
        write_register(addr, value);
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Right after reset the list is empty: nothing can be read, written or
    // deleted, an insert past the end is refused, and an append works.
    task automatic test_empty_list();
        send_request(iida_pkg::REQ_READ,   7'd0, DATA_ONES);
        send_request(iida_pkg::REQ_WRITE,  7'd0, DATA_MAX);
        send_request(iida_pkg::REQ_DELETE, 7'd0, '0);
        send_request(iida_pkg::REQ_INSERT, 7'd1, DATA_MIN);
        send_request(iida_pkg::REQ_INSERT, 7'd0, DATA_MAX);
    endtask

    // Builds a short list from the data extremes and edits it: insert at the
    // head and the tail, overwrite, delete from the head so the vacated top
    // cell clears, and positions at and far past the length.
    task automatic test_list_edits();
        send_request(iida_pkg::REQ_INSERT, 7'd1,   DATA_MIN);
        send_request(iida_pkg::REQ_INSERT, 7'd0,   DATA_ONES);
        send_request(iida_pkg::REQ_READ,   7'd2,   '0);
        send_request(iida_pkg::REQ_WRITE,  7'd1,   '0);
        send_request(iida_pkg::REQ_READ,   7'd1,   DATA_MAX);
        send_request(iida_pkg::REQ_DELETE, 7'd3,   '0);
        send_request(iida_pkg::REQ_DELETE, 7'd0,   DATA_MAX);
        send_request(iida_pkg::REQ_READ,   7'd2,   '0);
        send_request(iida_pkg::REQ_READ,   7'd127, '0);
        send_request(iida_pkg::REQ_INSERT, 7'd127, DATA_MAX);
    endtask

    // A full list refuses inserts; freeing the last cell makes room again.
    task automatic test_full_list();
        settle_and_configure(REG_START_LENGTH, LIST_DEPTH);
        send_request(iida_pkg::REQ_INSERT, 7'd0,  DATA_MAX);
        send_request(iida_pkg::REQ_READ,   7'd63, '0);
        send_request(iida_pkg::REQ_DELETE, 7'd63, '0);
        send_request(iida_pkg::REQ_INSERT, 7'd63, 32'h5A5A_A5A5);
        send_request(iida_pkg::REQ_READ,   7'd64, '0);
        send_request(iida_pkg::REQ_DELETE, 7'd64, '0);
    endtask

    // Register corner cases: an oversized start length saturates, only the
    // low seven bits of the written word count, an unmapped address is
    // ignored, and a length of one can be deleted down to empty.
    task automatic test_register_corners();
        settle_and_configure(REG_START_LENGTH, 32'd127);
        send_request(iida_pkg::REQ_READ, 7'd64, '0);
        settle_and_configure(REG_START_LENGTH, 32'hFFFF_FF85);
        send_request(iida_pkg::REQ_READ, 7'd4, '0);
        settle_and_configure(REG_UNMAPPED, 32'd20);
        send_request(iida_pkg::REQ_READ, 7'd5, '0);
        settle_and_configure(REG_START_LENGTH, 32'd1);
        send_request(iida_pkg::REQ_DELETE, 7'd0, '0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic in phases. Each phase loads its own start length and
    // leans toward growing, shrinking or holding the list. Most requests name
    // a position that is legal for the current length, so the list really
    // moves; about one in eight names any 7-bit position, and some aim right
    // at the length, where the read, write and delete boundaries sit.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned         ins_pct;
        int unsigned         del_pct;
        int unsigned         phase_items;
        int unsigned         sent;
        int unsigned         burst;
        int unsigned         pick;
        bit                  quiet;
        logic [31:0]         start_value;
        iida_pkg::t_req_type kind;
        logic [6:0]          pos;
        logic [31:0]         value;
        for (int phase = 0; phase < 6; phase++) begin
            quiet = 1'b0;
            phase_items = 220;
            case (phase)
                0: begin start_value = 0;                         ins_pct = 50; del_pct = 15; end
                1: begin start_value = LIST_DEPTH;                ins_pct = 40; del_pct = 20; end
                2: begin start_value = $urandom_range(1, 63);     ins_pct = 30; del_pct = 30; end
                3: begin start_value = 127;                       ins_pct = 10; del_pct = 50; end
                4: begin start_value = $urandom_range(0, 64);     ins_pct = 30; del_pct = 30;
                         quiet = 1'b1; end
                default: begin start_value = $urandom_range(0, 127); ins_pct = 35; del_pct = 30; end
            endcase
            settle_and_configure(REG_START_LENGTH, start_value);
            // The full-rate phase turns off receiver stalls and sender gaps.
            receiver_quiet = quiet;
            sent = 0;
            while (sent < phase_items) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    pick = $urandom_range(0, 99);
                    if (pick < ins_pct)
                        kind = iida_pkg::REQ_INSERT;
                    else if (pick < ins_pct + del_pct)
                        kind = iida_pkg::REQ_DELETE;
                    else if ($urandom_range(0, 1) == 0)
                        kind = iida_pkg::REQ_READ;
                    else
                        kind = iida_pkg::REQ_WRITE;

                    if ($urandom_range(0, 7) == 0)
                        pos = 7'($urandom_range(0, 127));
                    else if ($urandom_range(0, 9) == 0)
                        pos = shadow_len[6:0];
                    else if (kind == iida_pkg::REQ_INSERT)
                        pos = 7'($urandom_range(0, shadow_len));
                    else
                        pos = (shadow_len == 0) ? 7'd0 : 7'($urandom_range(0, shadow_len - 1));

                    // Mostly random words, with the range extremes now and then.
                    case ($urandom_range(0, 19))
                        0:       value = DATA_MAX;
                        1:       value = DATA_MIN;
                        2:       value = DATA_ONES;
                        3:       value = '0;
                        default: value = $urandom;
                    endcase
                    send_request(kind, pos, value);
                    sent++;
                end
                if (!quiet) begin
                    pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
                    // Now and then let the block run completely dry.
                    if ($urandom_range(0, 24) == 0)
                        drain_results();
                end
            end
            receiver_quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_req_type     <= iida_pkg::REQ_READ;
        i_position     <= '0;
        i_data         <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        mismatch_count = 0;
        requests_sent  = 0;
        results_checked = 0;
        config_writes  = 0;
        receiver_quiet = 1'b0;
        foreach (accepted_by_kind[k]) accepted_by_kind[k] = 0;
        // Reset leaves start_length at zero: empty list, all cells cleared.
        shadow_start = '0;
        load_start_length();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_list_edits();
        test_full_list();
        test_register_corners();
        test_random_traffic();

        // Wait for the last results, then keep watching the idle block in case it
        // produces anything that was not asked for.
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests and %0d register writes; %0d results checked",
                 requests_sent, config_writes, results_checked);
        $display("accepted reads %0d, writes %0d, inserts %0d, deletes %0d",
                 accepted_by_kind[iida_pkg::REQ_READ], accepted_by_kind[iida_pkg::REQ_WRITE],
                 accepted_by_kind[iida_pkg::REQ_INSERT], accepted_by_kind[iida_pkg::REQ_DELETE]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/iida_pkg.sv
hdl/iida_cell.sv
hdl/iida_result_queue.sv
hdl/indexed_insert_delete_array_core.sv
dv/indexed_insert_delete_array_core_tb.sv
